// File: rtl/lpmb_pkg.sv
// Shared types and constants for the length-prefixed message buffer.
package lpmb_pkg;

    localparam int DEF_BUF_DEPTH = 4096;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 16;
    localparam int STATUS_W      = 2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_SHORT = 2'd3;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   out_byte;
        logic                first_of_message;
        logic                last_of_message;
        logic [LEN_W-1:0]    message_length;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI
    } state_t;

endpackage

// File: rtl/lpmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lpmb_ctrl.sv
// Ring pointer, framing state and sequencer around the byte store.
module lpmb_ctrl
    import lpmb_pkg::*;
#(
    parameter int BUF_DEPTH = DEF_BUF_DEPTH,
    parameter int PTR_W     = $clog2(BUF_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  in_item_t          in_item,
    input  logic              out_free,
    output logic              in_ready,
    output logic              res_valid,
    output out_item_t         res,
    output logic              ram_wr_en,
    output logic [PTR_W-1:0]  ram_wr_addr,
    output logic [BYTE_W-1:0] ram_wr_data,
    output logic              ram_rd_en,
    output logic [PTR_W-1:0]  ram_rd_addr,
    input  logic [BYTE_W-1:0] ram_rd_data
);

    localparam int CNT_W = $clog2(BUF_DEPTH + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [LEN_W-1:0]   offset_reg, offset_next;
    logic [LEN_W-1:0]   cur_len_reg, cur_len_next;
    logic [BYTE_W-1:0]  lo_reg, lo_next;

    logic               accept;
    logic [LEN_W-1:0]   hdr_len;
    logic [LEN_W-1:0]   hdr_len_eff;
    logic               hdr_short;
    logic               hdr_incomplete;
    logic [LEN_W:0]     offset_inc;
    logic               body_last;
    logic               hdr_last;
    logic               ring_full;
    logic               too_few;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(BUF_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    assign ring_full  = (fill_reg >= CNT_W'(BUF_DEPTH));
    assign too_few    = (fill_reg < CNT_W'(2));
    assign offset_inc = {1'b0, offset_reg} + (LEN_W+1)'(1);
    assign body_last  = (offset_inc >= {1'b0, cur_len_reg});

    // header: low byte captured in RD_LO, high byte arrives in RD_HI
    assign hdr_len        = {ram_rd_data, lo_reg};
    assign hdr_short      = (hdr_len < LEN_W'(2));
    assign hdr_len_eff    = hdr_short ? LEN_W'(2) : hdr_len;
    assign hdr_incomplete = (CMP_W'(fill_reg) < CMP_W'(hdr_len_eff));
    assign hdr_last       = ((LEN_W+1)'(1) >= {1'b0, hdr_len_eff});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_item.action == ACT_READ)
                    && !((offset_reg == '0) && too_few))
                begin
                    state_next = ST_RD_LO;
                end
            end
            ST_RD_LO:
            begin
                state_next = (offset_reg == '0) ? ST_RD_HI : ST_IDLE;
            end
            ST_RD_HI:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        offset_next  = offset_reg;
        cur_len_next = cur_len_reg;
        lo_next      = lo_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = tail_reg;
        ram_wr_data  = in_item.data_byte;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = head_reg;
        res_valid    = 1'b0;
        res          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.action == ACT_WRITE)
                    begin
                        res_valid = 1'b1;
                        if (ring_full)
                        begin
                            res.status = STAT_FULL;
                        end
                        else
                        begin
                            ram_wr_en = 1'b1;
                            tail_next = next_pos(tail_reg);
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    else if ((offset_reg == '0) && too_few)
                    begin
                        res_valid  = 1'b1;
                        res.status = STAT_EMPTY;
                    end
                    else
                    begin
                        ram_rd_en = 1'b1;
                    end
                end
            end
            ST_RD_LO:
            begin
                if (offset_reg == '0)
                begin
                    lo_next     = ram_rd_data;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = next_pos(head_reg);
                end
                else
                begin
                    res_valid            = 1'b1;
                    res.out_byte         = ram_rd_data;
                    res.last_of_message  = body_last;
                    res.message_length   = cur_len_reg;
                    head_next            = next_pos(head_reg);
                    fill_next            = fill_reg - CNT_W'(1);
                    offset_next          = body_last ? '0 : offset_inc[LEN_W-1:0];
                end
            end
            ST_RD_HI:
            begin
                res_valid = 1'b1;
                if (hdr_incomplete)
                begin
                    res.status = STAT_EMPTY;
                end
                else
                begin
                    res.status           = hdr_short ? STAT_SHORT : STAT_OK;
                    res.out_byte         = lo_reg;
                    res.first_of_message = 1'b1;
                    res.last_of_message  = hdr_last;
                    res.message_length   = hdr_len_eff;
                    cur_len_next         = hdr_len_eff;
                    head_next            = next_pos(head_reg);
                    fill_next            = fill_reg - CNT_W'(1);
                    offset_next          = hdr_last ? '0 : LEN_W'(1);
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            offset_reg  <= '0;
            cur_len_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            offset_reg  <= offset_next;
            cur_len_reg <= cur_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(BUF_DEPTH))
        else $error("fill count above ring depth");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("item taken while a read is in flight");

    a_offset_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (offset_reg != '0) |-> (offset_reg < cur_len_reg))
        else $error("read offset past message length");

    a_hdr_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_HI) |-> (offset_reg == '0) && ($past(state_reg) == ST_RD_LO))
        else $error("header high byte fetched outside message start");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after result");

endmodule

// File: rtl/length_prefixed_message_buffer.sv
// Length-prefixed message buffer: byte ring, framing control and result register.
//
// Usage:
//   in channel  (in_valid / in_ready / in_item): action 0 appends data_byte to the
//   ring, action 1 fetches the next byte of the message at the head, once all of
//   that message (length from its two little-endian header bytes) is stored.
//   out channel (out_valid / out_ready / out_item): one result per transfer in,
//   with status, the byte, first/last marks and the message length.
// Path from input transfer to result valid: write, or read refused for fewer
//   than two stored bytes: result register only; read inside a message: store
//   read, then result register; read at a message start: low and high header
//   byte reads, one read per cycle, then result register.
// Throughput: one write per cycle while the result register is free; a read item
//   occupies the sequencer until its result is produced, set by the single read port
//   of the byte store and its registered read data.
// Reset empties the ring at once (pointers and counts cleared; store contents
//   are not cleared and are never read before written).
// A stalled receiver holds the result register; a new input transfer is still
//   taken in the cycle the pending result leaves.
module length_prefixed_message_buffer
    import lpmb_pkg::*;
#(
    parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int PTR_W = $clog2(BUF_DEPTH);

    logic              out_free;
    logic              res_valid;
    out_item_t         res;
    logic              ram_wr_en;
    logic [PTR_W-1:0]  ram_wr_addr;
    logic [BYTE_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [PTR_W-1:0]  ram_rd_addr;
    logic [BYTE_W-1:0] ram_rd_data;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    lpmb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lpmb_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .PTR_W     (PTR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_item     (in_item),
        .out_free    (out_free),
        .in_ready    (in_ready),
        .res_valid   (res_valid),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    assign out_free = !out_valid_reg || out_ready;

    // only one item in flight, so the register is free whenever a result lands
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the length-prefixed message buffer.
`timescale 1ns / 100ps

module testbench;
    import lpmb_pkg::*;

    localparam int DEPTH       = DEF_BUF_DEPTH;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int RANDOM_ITEMS = 780;

    typedef struct {
        logic              action;
        logic [BYTE_W-1:0] data;
        bit                typed;
        out_item_t         want;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    // framing model state
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    logic [PTR_W-1:0]  rd_ptr;
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W:0]    bytes_held;
    logic [LEN_W-1:0]  msg_pos;
    logic [LEN_W-1:0]  msg_len;

    out_item_t   pending_results[$];
    stim_row_t   dir_rows[$];
    int          err_cnt;
    int          cycle_cnt;
    int          n_in;
    int          n_bytes_out;
    int          n_msgs;
    int          n_refused;
    int          n_dropped;
    int          n_short;

    length_prefixed_message_buffer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one byte per write, one message byte per read once the head message is whole
    function automatic out_item_t frame_step(in_item_t it);
        out_item_t        r;
        logic [LEN_W-1:0] hdr;
        logic [PTR_W-1:0] nxt;
        logic             whole;
        logic             corrected;
        r = '0;
        if (it.action == ACT_WRITE)
        begin
            if (bytes_held >= (PTR_W+1)'(DEPTH))
                r.status = STAT_FULL;
            else
            begin
                ring_mem[wr_ptr] = it.data_byte;
                wr_ptr = wr_ptr + PTR_W'(1);
                bytes_held = bytes_held + (PTR_W+1)'(1);
            end
        end
        else
        begin
            whole = 1'b1;
            if (msg_pos == '0)
            begin
                if (bytes_held < (PTR_W+1)'(2))
                    whole = 1'b0;
                else
                begin
                    nxt = rd_ptr + PTR_W'(1);
                    hdr = {ring_mem[nxt], ring_mem[rd_ptr]};
                    corrected = (hdr < LEN_W'(2));
                    if (corrected)
                        hdr = LEN_W'(2);
                    if (LEN_W'(bytes_held) < hdr)
                        whole = 1'b0;
                    else
                    begin
                        msg_len = hdr;
                        r.first_of_message = 1'b1;
                        if (corrected)
                            r.status = STAT_SHORT;
                    end
                end
            end
            if (!whole)
                r.status = STAT_EMPTY;
            else
            begin
                r.out_byte       = ring_mem[rd_ptr];
                r.message_length = msg_len;
                rd_ptr     = rd_ptr + PTR_W'(1);
                bytes_held = bytes_held - (PTR_W+1)'(1);
                msg_pos    = msg_pos + LEN_W'(1);
                if (msg_pos >= msg_len)
                begin
                    r.last_of_message = 1'b1;
                    msg_pos = '0;
                end
            end
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones, none during recurring gap-free stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_cnt / 1024) % 5 == 2)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic stim_row_t wr_row(logic [BYTE_W-1:0] d);
        stim_row_t s;
        s.action = ACT_WRITE;
        s.data   = d;
        s.typed  = 1'b1;
        s.want   = '0;
        return s;
    endfunction

    function automatic stim_row_t rd_row(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] b,
                                         logic f, logic l, logic [LEN_W-1:0] len, bit typed);
        stim_row_t s;
        s.action                = ACT_READ;
        s.data                  = BYTE_W'($urandom_range(0, 255));
        s.typed                 = typed;
        s.want.status           = st;
        s.want.out_byte         = b;
        s.want.first_of_message = f;
        s.want.last_of_message  = l;
        s.want.message_length   = len;
        return s;
    endfunction

    task automatic send_item(input logic act, input logic [BYTE_W-1:0] d,
                             input bit typed, input out_item_t want);
        in_item_t  it;
        out_item_t pred;
        int        gap;
        it.action    = act;
        it.data_byte = d;
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        pred = frame_step(it);
        pending_results.push_back(typed ? want : pred);
        n_in++;
        case (pred.status)
            STAT_EMPTY: n_refused++;
            STAT_FULL:  n_dropped++;
            STAT_SHORT: n_short++;
            default: ;
        endcase
        if (act == ACT_READ && pred.status != STAT_EMPTY)
            n_bytes_out++;
        if (pred.last_of_message)
            n_msgs++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int n_items);
        logic [BYTE_W-1:0] msg_bytes[$];
        int                len;
        int                r;
        int                k;
        for (int n = 0; n < n_items; n++)
        begin
            if (n == n_items / 2)
                wait_results_drained();
            if (msg_bytes.size() == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    len = $urandom_range(0, 1);
                else if (r < 85)
                    len = $urandom_range(2, 24);
                else if (r < 97)
                    len = $urandom_range(25, 120);
                else
                    len = $urandom_range(130, 300);
                msg_bytes.push_back(len[7:0]);
                msg_bytes.push_back(len[15:8]);
                for (k = 2; k < len; k++)
                    msg_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) < 45)
                send_item(ACT_READ, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            else
                send_item(ACT_WRITE, msg_bytes.pop_front(), 1'b0, '0);
        end
        while (msg_bytes.size() != 0)
            send_item(ACT_WRITE, msg_bytes.pop_front(), 1'b0, '0);
        while (bytes_held != 0 || msg_pos != 0)
            send_item(ACT_READ, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // header longer than the ring: never completes and locks it until reset, so it comes last
    task automatic run_ring_extremes();
        logic [LEN_W-1:0] big_len;
        big_len = LEN_W'(DEPTH + 1);
        send_item(ACT_WRITE, big_len[7:0], 1'b0, '0);
        send_item(ACT_WRITE, big_len[15:8], 1'b0, '0);
        send_item(ACT_READ, 8'h00, 1'b0, '0);
        repeat (6) send_item(ACT_WRITE, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
        repeat (3) send_item(ACT_READ, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic flag(input string fld, input logic [LEN_W-1:0] want,
                        input logic [LEN_W-1:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, want, got);
        err_cnt++;
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, out_item);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.status !== want.status)
                    flag("status", LEN_W'(want.status), LEN_W'(out_item.status));
                if (out_item.out_byte !== want.out_byte)
                    flag("out_byte", LEN_W'(want.out_byte), LEN_W'(out_item.out_byte));
                if (out_item.first_of_message !== want.first_of_message)
                    flag("first_of_message", LEN_W'(want.first_of_message),
                         LEN_W'(out_item.first_of_message));
                if (out_item.last_of_message !== want.last_of_message)
                    flag("last_of_message", LEN_W'(want.last_of_message),
                         LEN_W'(out_item.last_of_message));
                if (out_item.message_length !== want.message_length)
                    flag("message_length", want.message_length, out_item.message_length);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: bursts of ready with random stalls between them
    initial
    begin
        int g;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            g = pick_gap();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    initial
    begin
        stim_row_t row;
        rst_n      = 1'b0;
        in_valid   <= 1'b0;
        in_item    <= '0;
        err_cnt    = 0;
        cycle_cnt  = 0;
        rd_ptr     = '0;
        wr_ptr     = '0;
        bytes_held = '0;
        msg_pos    = '0;
        msg_len    = '0;

        // empty ring, short headers of 0 and 1, partial message, plain messages
        dir_rows.push_back(rd_row(STAT_EMPTY, 8'h00, 1'b0, 1'b0, 16'd0, 1'b1));
        dir_rows.push_back(wr_row(8'h00));
        dir_rows.push_back(rd_row(STAT_EMPTY, 8'h00, 1'b0, 1'b0, 16'd0, 1'b1));
        dir_rows.push_back(wr_row(8'h00));
        dir_rows.push_back(rd_row(STAT_SHORT, 8'h00, 1'b1, 1'b0, 16'd2, 1'b1));
        dir_rows.push_back(rd_row(STAT_OK,    8'h00, 1'b0, 1'b1, 16'd2, 1'b1));
        dir_rows.push_back(wr_row(8'h01));
        dir_rows.push_back(wr_row(8'h00));
        dir_rows.push_back(rd_row(STAT_SHORT, 8'h01, 1'b1, 1'b0, 16'd2, 1'b1));
        dir_rows.push_back(rd_row(STAT_OK,    8'h00, 1'b0, 1'b1, 16'd2, 1'b1));
        dir_rows.push_back(wr_row(8'h05));
        dir_rows.push_back(wr_row(8'h00));
        dir_rows.push_back(wr_row(8'hFF));
        dir_rows.push_back(rd_row(STAT_EMPTY, 8'h00, 1'b0, 1'b0, 16'd0, 1'b1));
        dir_rows.push_back(wr_row(8'h80));
        dir_rows.push_back(wr_row(8'h7F));
        dir_rows.push_back(rd_row(STAT_OK, 8'h05, 1'b1, 1'b0, 16'd5, 1'b1));
        dir_rows.push_back(rd_row(STAT_OK, 8'h00, 1'b0, 1'b0, 16'd5, 1'b1));
        dir_rows.push_back(rd_row(STAT_OK, 8'hFF, 1'b0, 1'b0, 16'd5, 1'b1));
        dir_rows.push_back(rd_row(STAT_OK, 8'h80, 1'b0, 1'b0, 16'd5, 1'b1));
        dir_rows.push_back(rd_row(STAT_OK, 8'h7F, 1'b0, 1'b1, 16'd5, 1'b1));
        dir_rows.push_back(wr_row(8'h02));
        dir_rows.push_back(wr_row(8'h00));
        dir_rows.push_back(rd_row(STAT_OK, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0));
        dir_rows.push_back(rd_row(STAT_OK, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_item(row.action, row.data, row.typed, row.want);
        end
        run_random(RANDOM_ITEMS);
        wait_results_drained();
        run_ring_extremes();

        wait_results_drained();
        repeat (8) @(posedge clk);
        $display("Run: %0d transfers in, %0d bytes out in %0d messages, %0d short headers,",
                 n_in, n_bytes_out, n_msgs, n_short);
        $display("     %0d refused reads, %0d dropped writes, oversized header at the end",
                 n_refused, n_dropped);
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
